[design/u8d_pkg.sv]
// u8d_pkg: shared types, constants and code point classification for the utf-8 decoder
// no dependencies; used by every file of the block
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned OFFS_W   = 32;
  localparam int unsigned LEN_W    = 3;

  // queue between front and back, a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam logic [LEN_W-1:0] SEQ_LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] SEQ_LEN_2    = 3'd2;
  localparam logic [LEN_W-1:0] SEQ_LEN_3    = 3'd3;
  localparam logic [LEN_W-1:0] SEQ_LEN_4    = 3'd4;

  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_NONCH_LO  = 21'h00FDD0;
  localparam logic [CP_W-1:0] CP_NONCH_HI  = 21'h00FDEF;
  localparam logic [15:0]     CP_NONCH_END = 16'hFFFE;
  localparam logic [CP_W-1:0] CP_CTL_LO    = 21'h00007F;
  localparam logic [CP_W-1:0] CP_CTL_HI    = 21'h00009F;
  localparam logic [CP_W-1:0] CP_MIN_2     = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3     = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4     = 21'h010000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  // one entry of the queue: a result before classification
  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [OFFS_W-1:0] start_offset;
    logic              end_marker;
    logic              decode_error;
  } q_entry_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [OFFS_W-1:0] start_offset;
    logic              end_marker;
    logic              decode_error;
    logic              surrogate_flag;
    logic              noncharacter_flag;
    logic              control_flag;
  } out_item_t;

  function automatic logic is_surrogate(input logic [CP_W-1:0] cp);
    return (cp >= CP_SURR_LO) && (cp <= CP_SURR_HI);
  endfunction

endpackage

`default_nettype wire

[design/u8d_if.sv]
// u8d_in_if, u8d_out_if: valid/ready channels of the utf-8 decoder
// depends on u8d_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u8d_out_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::CP_W-1:0]     code_point;
  logic [u8d_pkg::OFFS_W-1:0]   start_offset;
  logic                         end_marker;
  logic                         decode_error;
  logic                         surrogate_flag;
  logic                         noncharacter_flag;
  logic                         control_flag;

  modport source (output valid, output code_point, output start_offset,
                  output end_marker, output decode_error, output surrogate_flag,
                  output noncharacter_flag, output control_flag, input ready);
  modport sink   (input valid, input code_point, input start_offset,
                  input end_marker, input decode_error, input surrogate_flag,
                  input noncharacter_flag, input control_flag, output ready);
endinterface

`default_nettype wire

[design/u8d_front.sv]
// u8d_front: accepts bytes, tracks the utf-8 sequence state and pushes raw results
// depends on u8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8d_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  u8d_pkg::in_item_t      item_i,
  output logic                   push_o,
  output u8d_pkg::q_entry_t      entry_o
);

  logic [u8d_pkg::CP_W-1:0]   partial_q, partial_d;
  logic [1:0]                 remain_q, remain_d;
  logic [u8d_pkg::LEN_W-1:0]  len_q, len_d;
  logic                       after_cr_q, after_cr_d;
  logic [u8d_pkg::OFFS_W-1:0] pos_q, pos_d;
  logic [u8d_pkg::OFFS_W-1:0] start_q, start_d;

  logic [7:0]                 b;
  logic [u8d_pkg::CP_W-1:0]   merged;
  logic                       value_ok;

  assign b      = item_i.data_byte;
  assign merged = {partial_q[u8d_pkg::CP_W-7:0], b[5:0]};

  always_comb begin
    value_ok = (merged <= u8d_pkg::CP_MAX) && !u8d_pkg::is_surrogate(merged);
    unique case (len_q)
      u8d_pkg::SEQ_LEN_2: if (merged < u8d_pkg::CP_MIN_2) value_ok = 1'b0;
      u8d_pkg::SEQ_LEN_3: if (merged < u8d_pkg::CP_MIN_3) value_ok = 1'b0;
      u8d_pkg::SEQ_LEN_4: if (merged < u8d_pkg::CP_MIN_4) value_ok = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    partial_d  = partial_q;
    remain_d   = remain_q;
    len_d      = len_q;
    after_cr_d = after_cr_q;
    pos_d      = pos_q;
    start_d    = start_q;
    push_o     = 1'b0;
    entry_o    = '0;

    if (accept_i) begin
      if (item_i.end_of_stream) begin
        push_o               = 1'b1;
        entry_o.end_marker   = 1'b1;
        entry_o.decode_error = (remain_q != 2'd0);
        entry_o.start_offset = (remain_q != 2'd0) ? start_q : pos_q;
        partial_d  = '0;
        remain_d   = 2'd0;
        len_d      = u8d_pkg::SEQ_LEN_NONE;
        after_cr_d = 1'b0;
      end else begin
        pos_d = pos_q + 32'd1;
        if (remain_q == 2'd0) begin
          after_cr_d = 1'b0;
          start_d    = pos_q;
          entry_o.start_offset = pos_q;
          if (!b[7]) begin
            // lf right after a cr is swallowed
            if (!(after_cr_q && b == u8d_pkg::BYTE_LF)) begin
              push_o = 1'b1;
              if (b == u8d_pkg::BYTE_CR) begin
                after_cr_d         = 1'b1;
                entry_o.code_point = {13'd0, u8d_pkg::BYTE_LF};
              end else begin
                entry_o.code_point = {13'd0, b};
              end
            end
          end else if (b[7:5] == 3'b110) begin
            partial_d = {16'd0, b[4:0]};
            remain_d  = 2'd1;
            len_d     = u8d_pkg::SEQ_LEN_2;
          end else if (b[7:4] == 4'b1110) begin
            partial_d = {17'd0, b[3:0]};
            remain_d  = 2'd2;
            len_d     = u8d_pkg::SEQ_LEN_3;
          end else if (b[7:3] == 5'b11110) begin
            partial_d = {18'd0, b[2:0]};
            remain_d  = 2'd3;
            len_d     = u8d_pkg::SEQ_LEN_4;
          end else begin
            push_o               = 1'b1;
            entry_o.decode_error = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          // bad continuation, byte dropped
          partial_d            = '0;
          remain_d             = 2'd0;
          push_o               = 1'b1;
          entry_o.decode_error = 1'b1;
          entry_o.start_offset = start_q;
        end else begin
          remain_d = remain_q - 2'd1;
          if (remain_q == 2'd1) begin
            partial_d            = '0;
            push_o               = 1'b1;
            entry_o.start_offset = start_q;
            if (value_ok) begin
              entry_o.code_point = merged;
            end else begin
              entry_o.decode_error = 1'b1;
            end
          end else begin
            partial_d = merged;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q  <= '0;
      remain_q   <= 2'd0;
      len_q      <= u8d_pkg::SEQ_LEN_NONE;
      after_cr_q <= 1'b0;
      pos_q      <= '0;
      start_q    <= '0;
    end else begin
      partial_q  <= partial_d;
      remain_q   <= remain_d;
      len_q      <= len_d;
      after_cr_q <= after_cr_d;
      pos_q      <= pos_d;
      start_q    <= start_d;
    end
  end

endmodule

`default_nettype wire

[design/u8d_queue.sv]
// u8d_queue: short fifo of raw results between front and back
// depends on u8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  u8d_pkg::q_entry_t entry_i,
  output logic              not_full_o,
  output logic              not_empty_o,
  input  wire logic         pop_i,
  output u8d_pkg::q_entry_t entry_o
);

  u8d_pkg::q_entry_t               mem_q [u8d_pkg::QUEUE_DEPTH];
  logic [u8d_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [u8d_pkg::QCNT_W-1:0]      count_q;
  logic                            do_push, do_pop;

  assign not_full_o  = (count_q != u8d_pkg::QCNT_W'(u8d_pkg::QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign entry_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers wrap on their own since the depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/u8d_back.sv]
// u8d_back: classifies queued results and holds them in the output register
// depends on u8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8d_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          avail_i,
  input  u8d_pkg::q_entry_t  entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output u8d_pkg::out_item_t out_item_o
);

  logic               valid_q;
  u8d_pkg::out_item_t item_q, item_d;
  logic               is_cp;

  assign pop_o       = avail_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;
  assign is_cp       = !entry_i.end_marker && !entry_i.decode_error;

  always_comb begin
    item_d.code_point        = entry_i.code_point;
    item_d.start_offset      = entry_i.start_offset;
    item_d.end_marker        = entry_i.end_marker;
    item_d.decode_error      = entry_i.decode_error;
    item_d.surrogate_flag    = is_cp && u8d_pkg::is_surrogate(entry_i.code_point);
    item_d.noncharacter_flag = is_cp && (
        ((entry_i.code_point >= u8d_pkg::CP_NONCH_LO) &&
         (entry_i.code_point <= u8d_pkg::CP_NONCH_HI)) ||
        ((entry_i.code_point <= u8d_pkg::CP_MAX) &&
         (entry_i.code_point[15:0] >= u8d_pkg::CP_NONCH_END)));
    item_d.control_flag      = is_cp && (entry_i.code_point >= u8d_pkg::CP_CTL_LO) &&
                               (entry_i.code_point <= u8d_pkg::CP_CTL_HI);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[design/utf8_decode_newline_check_unit.sv]
// utf8_decode_newline_check_unit: top level of the utf-8 decoder with newline handling
// depends on u8d_pkg, u8d_if, u8d_front, u8d_queue, u8d_back
//
//   channel | dir | beat payload
//   --------+-----+-----------------------------------------------------------
//   in_ch   | in  | data_byte, end_of_stream
//   out_ch  | out | code_point, start_offset, end_marker, decode_error, flags
//
// one byte per cycle unless the queue is full, each decoded in the cycle it is taken
// a result goes through the queue and then the output register to out_ch
// in_ch.ready drops only when the two-entry result queue is full
// reset clears sequence state, offsets and the queue at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module utf8_decode_newline_check_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch
);

  u8d_pkg::in_item_t  in_item;
  u8d_pkg::q_entry_t  push_entry, pop_entry;
  u8d_pkg::out_item_t out_item;
  logic               accept, push, not_full, not_empty, pop;

  assign in_item.data_byte     = in_ch.data_byte;
  assign in_item.end_of_stream = in_ch.end_of_stream;
  assign in_ch.ready           = not_full;
  assign accept                = in_ch.valid && not_full;

  u8d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  u8d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (push_entry),
    .not_full_o  (not_full),
    .not_empty_o (not_empty),
    .pop_i       (pop),
    .entry_o     (pop_entry)
  );

  u8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (not_empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_item_o  (out_item)
  );

  assign out_ch.code_point        = out_item.code_point;
  assign out_ch.start_offset      = out_item.start_offset;
  assign out_ch.end_marker        = out_item.end_marker;
  assign out_ch.decode_error      = out_item.decode_error;
  assign out_ch.surrogate_flag    = out_item.surrogate_flag;
  assign out_ch.noncharacter_flag = out_item.noncharacter_flag;
  assign out_ch.control_flag      = out_item.control_flag;

endmodule

`default_nettype wire

[design/u8d_checker.sv]
// u8d_checker: port-level checks of the utf-8 decoder, bound to the top level
// depends on u8d_pkg and utf8_decode_newline_check_unit
`timescale 1ns / 1ps
`default_nettype none

module u8d_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [u8d_pkg::CP_W-1:0]   code_point_i,
  input wire logic [u8d_pkg::OFFS_W-1:0] start_offset_i,
  input wire logic                       end_marker_i,
  input wire logic                       decode_error_i,
  input wire logic                       surrogate_flag_i,
  input wire logic                       noncharacter_flag_i,
  input wire logic                       control_flag_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i && $stable(code_point_i) &&
      $stable(start_offset_i) && $stable(end_marker_i) && $stable(decode_error_i))
    else $error("result beat changed while stalled");

  // end and error beats carry no code point and no flags
  a_no_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && (end_marker_i || decode_error_i) |->
      code_point_i == '0 && !surrogate_flag_i && !noncharacter_flag_i && !control_flag_i)
    else $error("end or error beat with code point or flags");

  // surrogates are rejected as errors, so the flag never shows
  a_no_surr: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |-> !surrogate_flag_i && code_point_i <= u8d_pkg::CP_MAX)
    else $error("surrogate or out-of-range code point delivered");

  // cr is always given as lf
  a_no_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |-> code_point_i != {13'd0, u8d_pkg::BYTE_CR})
    else $error("cr delivered without normalization");

endmodule

bind utf8_decode_newline_check_unit u8d_checker u_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_ch.valid),
  .out_ready_i         (out_ch.ready),
  .code_point_i        (out_ch.code_point),
  .start_offset_i      (out_ch.start_offset),
  .end_marker_i        (out_ch.end_marker),
  .decode_error_i      (out_ch.decode_error),
  .surrogate_flag_i    (out_ch.surrogate_flag),
  .noncharacter_flag_i (out_ch.noncharacter_flag),
  .control_flag_i      (out_ch.control_flag)
);

`default_nettype wire
